@@ rtl/mkd_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and lookup tables for the Morse key decoder.
package mkd_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 16;
   localparam int CSR_WIDTH           = 16;
   localparam int CSR_INDEX_WIDTH     = 2;
   localparam int SLOT_COUNT          = 5;
   localparam int SLOT_INDEX_WIDTH    = 3;
   localparam int LETTER_COUNT        = 26;
   localparam int DIGIT_COUNT         = 10;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DOT_MIN  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DASH_MIN = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_END_MIN  = 2'd2;

   localparam logic [CSR_WIDTH-1:0] DOT_MIN_RESET  = 16'd50;
   localparam logic [CSR_WIDTH-1:0] DASH_MIN_RESET = 16'd400;
   localparam logic [CSR_WIDTH-1:0] END_MIN_RESET  = 16'd1200;

   // Press classes as seen on the result channel.
   typedef enum logic [1:0] {
      KIND_DOT   = 2'd0,
      KIND_DASH  = 2'd1,
      KIND_END   = 2'd2,
      KIND_SHORT = 2'd3
   } kind_type;

   // Symbol slot codes.
   typedef logic [1:0] slot_type;
   localparam slot_type SLOT_DOT   = 2'd0;
   localparam slot_type SLOT_DASH  = 2'd1;
   localparam slot_type SLOT_EMPTY = 2'd2;

   typedef slot_type [SLOT_COUNT-1:0] slots_type;

   localparam logic [6:0] ASCII_A    = 7'd65;
   localparam logic [6:0] ASCII_ZERO = 7'd48;

   // Letters A..Z: slots 0..3 packed two bits each, slot 0 lowest.
   localparam logic [7:0] LETTER_CODES [LETTER_COUNT] = '{
      8'ha4, 8'h01, 8'h11, 8'h81, 8'ha8, 8'h10, 8'h85, 8'h00, 8'ha0, 8'h54,
      8'h91, 8'h04, 8'ha5, 8'ha1, 8'h95, 8'h14, 8'h45, 8'h84, 8'h80, 8'ha9,
      8'h90, 8'h40, 8'h94, 8'h41, 8'h51, 8'h05
   };

   // Digits 0..9: dash flags of slots 0..4, slot 0 in bit 0.
   localparam logic [SLOT_COUNT-1:0] DIGIT_CODES [DIGIT_COUNT] = '{
      5'h1f, 5'h1e, 5'h1c, 5'h18, 5'h10, 5'h00, 5'h01, 5'h03, 5'h07, 5'h0f
   };

   // Outcome of one character translation.
   typedef struct packed {
      logic       ok;
      logic [6:0] code;
   } char_type;

endpackage

@@ rtl/mkd_req_if.sv @@
`timescale 1ns / 1ps
// Key sample channel and result channel interfaces.
interface mkd_req_if;
   logic valid;
   logic ready;
   logic key_down;

   modport source (output valid, output key_down, input ready);
   modport sink   (input valid, input key_down, output ready);
endinterface

interface mkd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] press_kind;
   logic       char_done;
   logic       char_ok;
   logic [6:0] char_code;

   modport source (output valid, output press_kind, output char_done, output char_ok,
                   output char_code, input ready);
   modport sink   (input valid, input press_kind, input char_done, input char_ok,
                   input char_code, output ready);
endinterface

@@ rtl/mkd_classify.sv @@
`timescale 1ns / 1ps
// Press duration classifier against the three thresholds.
module mkd_classify #(
   parameter int CountWidth = mkd_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic [CountWidth-1:0]         press_ticks,
   input  logic [mkd_pkg::CSR_WIDTH-1:0] dot_min,
   input  logic [mkd_pkg::CSR_WIDTH-1:0] dash_min,
   input  logic [mkd_pkg::CSR_WIDTH-1:0] end_min,
   output mkd_pkg::kind_type             kind
);
   import mkd_pkg::*;

   localparam int CmpWidth = (CountWidth > CSR_WIDTH) ? CountWidth : CSR_WIDTH;

   logic [CmpWidth-1:0] ticks_ext;

   assign ticks_ext = CmpWidth'(press_ticks);

   // End wins over everything, even when thresholds are out of order.
   always_comb begin
      if (ticks_ext >= CmpWidth'(end_min)) begin
         kind = KIND_END;
      end else if (ticks_ext >= CmpWidth'(dash_min)) begin
         kind = KIND_DASH;
      end else if (ticks_ext >= CmpWidth'(dot_min)) begin
         kind = KIND_DOT;
      end else begin
         kind = KIND_SHORT;
      end
   end

endmodule

@@ rtl/mkd_translate.sv @@
`timescale 1ns / 1ps
// Symbol slot pattern to ASCII lookup for letters and digits.
module mkd_translate (
   input  mkd_pkg::slots_type slots,
   output mkd_pkg::char_type  result
);
   import mkd_pkg::*;

   logic [7:0]            letter_key;
   logic [SLOT_COUNT-1:0] digit_key;
   char_type              letter_hit;
   char_type              digit_hit;

   assign letter_key = {slots[3], slots[2], slots[1], slots[0]};

   always_comb begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
         digit_key[i] = (slots[i] == SLOT_DASH);
      end
   end

   // Scan from the top so the lowest matching entry wins.
   always_comb begin
      letter_hit = '0;
      for (int i = LETTER_COUNT - 1; i >= 0; i--) begin
         if (LETTER_CODES[i] == letter_key) begin
            letter_hit.ok   = 1'b1;
            letter_hit.code = 7'(ASCII_A + 7'(i));
         end
      end
   end

   always_comb begin
      digit_hit = '0;
      for (int i = DIGIT_COUNT - 1; i >= 0; i--) begin
         if (DIGIT_CODES[i] == digit_key) begin
            digit_hit.ok   = 1'b1;
            digit_hit.code = 7'(ASCII_ZERO + 7'(i));
         end
      end
   end

   assign result = (slots[SLOT_COUNT-1] == SLOT_EMPTY) ? letter_hit : digit_hit;

endmodule

@@ rtl/morse_key_decoder.sv @@
`timescale 1ns / 1ps
// Morse key decoder: times key presses and translates dot/dash patterns to ASCII.
// A release beat's result is presented from the output register in the next cycle.
// Throughput: one key sample beat per cycle while the result register is empty or
// draining; only the slot and counter update sit in the loop from one sample to the next.
// Reset (synchronous, active high): press counter and key history cleared, all slots
// empty, thresholds back to 50 / 400 / 1200 sample ticks, result register empty.
module morse_key_decoder #(
   parameter int CountWidth = mkd_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   mkd_req_if.sink                             req_bus,
   mkd_rsp_if.source                           rsp_bus,
   input  logic                                csr_wr_en,
   input  logic [mkd_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [mkd_pkg::CSR_WIDTH-1:0]       csr_wr_data
);
   import mkd_pkg::*;

   // Threshold registers.
   logic [CSR_WIDTH-1:0] dot_min_ff, dash_min_ff, end_min_ff;

   // Press timing and symbol state.
   logic [CountWidth-1:0]       press_ticks_ff, press_ticks_in;
   logic                        key_was_down_ff, key_was_down_in;
   slots_type                   slots_ff, slots_in;
   logic [SLOT_INDEX_WIDTH-1:0] slot_index_ff, slot_index_in;

   // Result register.
   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] press_kind_ff;
   logic       char_done_ff, char_ok_ff;
   logic [6:0] char_code_ff;

   logic                        beat_in;
   logic                        release_beat;
   kind_type                    kind;
   slots_type                   slots_upd;
   logic [SLOT_INDEX_WIDTH-1:0] slot_index_upd;
   logic                        char_done;
   char_type                    char_res;

   // Take a new sample whenever the result register is empty or drains this cycle.
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign beat_in       = req_bus.valid && req_bus.ready;
   assign release_beat  = beat_in && !req_bus.key_down && key_was_down_ff;

   mkd_classify #(
      .CountWidth (CountWidth)
   ) u_classify (
      .press_ticks (press_ticks_ff),
      .dot_min     (dot_min_ff),
      .dash_min    (dash_min_ff),
      .end_min     (end_min_ff),
      .kind        (kind)
   );

   // Fill the current slot; a too-short press uses it up but leaves it empty, and an end press finishes the character.
   always_comb begin
      slots_upd      = slots_ff;
      slot_index_upd = slot_index_ff;
      char_done      = 1'b0;
      if (kind == KIND_END) begin
         char_done = 1'b1;
      end else begin
         if (slot_index_ff < SLOT_INDEX_WIDTH'(SLOT_COUNT)) begin
            if (kind != KIND_SHORT) begin
               slots_upd[slot_index_ff] = (kind == KIND_DASH) ? SLOT_DASH : SLOT_DOT;
            end
            slot_index_upd = slot_index_ff + SLOT_INDEX_WIDTH'(1);
         end
         if (slot_index_upd >= SLOT_INDEX_WIDTH'(SLOT_COUNT)) begin
            char_done = 1'b1;
         end
      end
   end

   mkd_translate u_translate (
      .slots  (slots_upd),
      .result (char_res)
   );

   // Next state: count held ticks (saturating), act on the release tick only.
   always_comb begin
      press_ticks_in  = press_ticks_ff;
      key_was_down_in = key_was_down_ff;
      slots_in        = slots_ff;
      slot_index_in   = slot_index_ff;
      if (beat_in) begin
         if (req_bus.key_down) begin
            if (press_ticks_ff != '1) begin
               press_ticks_in = press_ticks_ff + CountWidth'(1);
            end
            key_was_down_in = 1'b1;
         end else if (key_was_down_ff) begin
            press_ticks_in  = '0;
            key_was_down_in = 1'b0;
            if (char_done) begin
               slots_in      = {SLOT_COUNT{SLOT_EMPTY}};
               slot_index_in = '0;
            end else begin
               slots_in      = slots_upd;
               slot_index_in = slot_index_upd;
            end
         end
      end
   end

   // Hold the result beat until the sink takes it.
   always_comb begin
      if (release_beat) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_min_ff      <= DOT_MIN_RESET;
         dash_min_ff     <= DASH_MIN_RESET;
         end_min_ff      <= END_MIN_RESET;
         press_ticks_ff  <= '0;
         key_was_down_ff <= 1'b0;
         slots_ff        <= {SLOT_COUNT{SLOT_EMPTY}};
         slot_index_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_DOT_MIN:  dot_min_ff  <= csr_wr_data;
               CSR_DASH_MIN: dash_min_ff <= csr_wr_data;
               CSR_END_MIN:  end_min_ff  <= csr_wr_data;
               default: begin
               end
            endcase
         end
         press_ticks_ff  <= press_ticks_in;
         key_was_down_ff <= key_was_down_in;
         slots_ff        <= slots_in;
         slot_index_ff   <= slot_index_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Payload needs no reset; load it on the release beat only.
   always_ff @(posedge clock) begin
      if (release_beat) begin
         press_kind_ff <= kind;
         char_done_ff  <= char_done;
         char_ok_ff    <= char_done && char_res.ok;
         char_code_ff  <= (char_done && char_res.ok) ? char_res.code : 7'd0;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.press_kind = press_kind_ff;
   assign rsp_bus.char_done  = char_done_ff;
   assign rsp_bus.char_ok    = char_ok_ff;
   assign rsp_bus.char_code  = char_code_ff;

endmodule
